@@ rtl/ocg_pkg.sv @@
// ----------------------------------------------------------------------------
// Occupancy grid ray update: shared definitions
// Grid geometry, stream layout, register indexes, operation codes and
// register reset values.
// ----------------------------------------------------------------------------
package ocg_pkg;

	localparam int GRID_SIZE     = 16;
	localparam int GRID_AW       = $clog2(GRID_SIZE);
	localparam int CELL_AW       = 2 * GRID_AW;
	localparam int CELL_COUNT    = GRID_SIZE * GRID_SIZE;
	localparam int CELL_W        = 16;
	localparam int RAY_STEPS_DEF = 26;

	// Q8.8 grid center and step divisor
	localparam int GRID_CTR_Q8 = (GRID_SIZE / 2) * 256;
	localparam int STEP_DIV    = 5;
	localparam int STEP_HALF   = STEP_DIV * 128;

	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam int S_TDATA_W = 88;
	localparam int M_TDATA_W = 24;

	typedef enum logic [1:0] {
		OP_RAY   = 2'd0,
		OP_READ  = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_HIT   = 2'd0,
		CFG_MISS  = 2'd1,
		CFG_NEAR  = 2'd2,
		CFG_RANGE = 2'd3
	} cfg_idx_t;

	localparam logic signed [15:0] HIT_INC_RST  = 16'sd721;
	localparam logic signed [15:0] MISS_INC_RST = -16'sd1507;
	localparam logic signed [15:0] NEAR_INC_RST = 16'sd2466;
	localparam logic        [15:0] MAX_RANGE_RST = 16'd1280;

endpackage

@@ rtl/ocg_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, read data registered.
// ----------------------------------------------------------------------------
module ocg_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/occupancy_grid_ray_update.sv @@
// ----------------------------------------------------------------------------
// Occupancy grid ray update
// 16x16 log-odds grid in one RAM; ray updates, cell reads and grid clears.
// ----------------------------------------------------------------------------
// Requests enter on the s_ stream (operation in s_tuser), one result per
// request leaves on the m_ stream. Registers are to be written on the cfg
// port only while the block is idle; the block itself does not enforce it.
// One request is in work at a time. A ray update walks RAY_STEPS points, one
// point per cycle through a four-stage point pipe that ends in one RAM
// read-modify-write per point. The result follows once the last point is
// written, and the block then returns to idle. A back-to-back write and read
// of the same cell is forwarded. Reads pass through a read state to the
// result; clears and out-of-range updates go straight to it, then to idle.
// Reset zeroes the grid at once through per-cell valid bits (a clear request
// does the same) and loads the register defaults.
// A result waits in the output register while m_tready is low; the block
// takes the next request meanwhile and holds its own result until the
// register frees.
// ----------------------------------------------------------------------------
module occupancy_grid_ray_update import ocg_pkg::*; #(
	parameter int RAY_STEPS = RAY_STEPS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// robot_x, robot_y, ray_dx, ray_dy, ray_range, read_row, read_col
	input  logic [S_TDATA_W-1:0] s_tdata,
	// operation
	input  logic [1:0]           s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// cell_value, cells_updated, target_reached, zero pad
	output logic [M_TDATA_W-1:0] m_tdata,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int NW    = $clog2(RAY_STEPS);
	localparam int ACC_W = 16 + NW;
	localparam int X_W   = ACC_W - 8;
	localparam int SH    = X_W + 3;
	localparam int M_W   = SH - 1;
	localparam int RECIP = ((2 ** SH) + STEP_DIV - 1) / STEP_DIV;
	localparam int Q_W   = X_W - 1;
	localparam int CW    = X_W + 2;

	localparam logic [NW-1:0]        LAST_N  = NW'(RAY_STEPS - 1);
	localparam logic [M_W-1:0]       RECIP_C = M_W'(RECIP);
	localparam logic signed [CW-1:0] GRID_HI = CW'(GRID_SIZE);
	localparam logic signed [CW-1:0] GRID_LO = CW'(0);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_WALK = 4'b0010,
		ST_READ = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	function automatic logic signed [CW-1:0] round_q8(input logic signed [17:0] a);
		logic [17:0]        mag;
		logic [17:0]        q;
		logic signed [CW-1:0] qe;
		mag = a[17] ? 18'(-a) : 18'(a);
		q   = (mag + 18'd128) >> 8;
		qe  = CW'(q);
		return a[17] ? -qe : qe;
	endfunction

	state_t state_q;

	logic signed [15:0] hit_inc_q, miss_inc_q, near_inc_q;
	logic        [15:0] max_range_q;

	// request fields
	op_t                op;
	logic signed [15:0] robot_x, robot_y, ray_dx, ray_dy;
	logic        [15:0] ray_range;
	logic [GRID_AW-1:0] read_row, read_col;
	logic               req;

	assign op        = op_t'(s_tuser);
	assign robot_x   = s_tdata[15:0];
	assign robot_y   = s_tdata[31:16];
	assign ray_dx    = s_tdata[47:32];
	assign ray_dy    = s_tdata[63:48];
	assign ray_range = s_tdata[79:64];
	assign read_row  = s_tdata[80 +: GRID_AW];
	assign read_col  = s_tdata[84 +: GRID_AW];

	assign s_tready = (state_q == ST_IDLE);
	assign req      = s_tvalid && s_tready;

	// ray geometry, held for the walk
	logic signed [CW-1:0]    r0_q, c0_q, re_q, ce_q;
	logic signed [15:0]      dx_q, dy_q;
	logic signed [ACC_W-1:0] acc_r_q, acc_c_q;
	logic [NW-1:0]           n_q;
	logic                    issue_q;

	// stage A: rounded magnitude of n*v
	logic             neg_r, neg_c;
	logic [ACC_W-1:0] mag_r, mag_c, rnd_r, rnd_c;

	always_comb begin
		neg_r = acc_r_q[ACC_W-1];
		neg_c = acc_c_q[ACC_W-1];
		mag_r = neg_r ? ACC_W'(-acc_r_q) : ACC_W'(acc_r_q);
		mag_c = neg_c ? ACC_W'(-acc_c_q) : ACC_W'(acc_c_q);
		rnd_r = mag_r + ACC_W'(STEP_HALF);
		rnd_c = mag_c + ACC_W'(STEP_HALF);
	end

	logic           v_s1, last_s1, neg_r_s1, neg_c_s1;
	logic [X_W-1:0] x_r_s1, x_c_s1;

	// stage B: divide by the step divisor through a reciprocal
	logic [X_W+M_W-1:0] prod_r, prod_c;

	assign prod_r = (X_W+M_W)'(x_r_s1) * (X_W+M_W)'(RECIP_C);
	assign prod_c = (X_W+M_W)'(x_c_s1) * (X_W+M_W)'(RECIP_C);

	logic           v_s2, last_s2, neg_r_s2, neg_c_s2;
	logic [Q_W-1:0] q_r_s2, q_c_s2;

	// stage C: point cell, bounds, classification, RAM read
	logic signed [CW-1:0] off_r, off_c, pr, pc;
	logic signed [CW:0]   dr, dc;
	logic                 in_b, is_end, near, upd_c, hit_c;
	logic signed [15:0]   inc_c;
	logic [CELL_AW-1:0]   walk_addr, ram_raddr;
	logic                 reached_q;
	logic [4:0]           cnt_q;

	always_comb begin
		off_r  = neg_r_s2 ? -CW'(q_r_s2) : CW'(q_r_s2);
		off_c  = neg_c_s2 ? -CW'(q_c_s2) : CW'(q_c_s2);
		pr     = r0_q + off_r;
		pc     = c0_q + off_c;
		dr     = {pr[CW-1], pr} - {re_q[CW-1], re_q};
		dc     = {pc[CW-1], pc} - {ce_q[CW-1], ce_q};
		in_b   = (pr > GRID_LO) && (pr < GRID_HI) && (pc > GRID_LO) && (pc < GRID_HI);
		is_end = (pr == re_q) && (pc == ce_q);
		near   = (dr >= -2'sd1) && (dr <= 2'sd1) && (dc >= -2'sd1) && (dc <= 2'sd1);
		upd_c  = v_s2 && in_b && (!reached_q || near);
		hit_c  = v_s2 && in_b && !reached_q && is_end;
		if (reached_q) begin
			inc_c = near_inc_q;
		end else if (is_end) begin
			inc_c = hit_inc_q;
		end else begin
			inc_c = miss_inc_q;
		end
		walk_addr = {pr[GRID_AW-1:0], pc[GRID_AW-1:0]};
		ram_raddr = (state_q == ST_IDLE) ? {read_row, read_col} : walk_addr;
	end

	logic               v_s3, last_s3, upd_s3;
	logic signed [15:0] inc_s3;
	logic [CELL_AW-1:0] raddr_q;

	// stage D: read data, forward, saturating add, write back
	logic [CELL_COUNT-1:0] valid_q;
	logic [CELL_W-1:0]     ram_rdata, wr_data_q, old_val, sat_val;
	logic [CELL_AW-1:0]    wr_addr_q;
	logic                  fwd_q, ram_we;
	logic [CELL_W:0]       sum;

	always_comb begin
		if (fwd_q && (wr_addr_q == raddr_q)) begin
			old_val = wr_data_q;
		end else if (valid_q[raddr_q]) begin
			old_val = ram_rdata;
		end else begin
			old_val = '0;
		end
		sum = {old_val[CELL_W-1], old_val} + {inc_s3[15], inc_s3};
		if (sum[CELL_W] != sum[CELL_W-1]) begin
			sat_val = sum[CELL_W] ? 16'h8000 : 16'h7FFF;
		end else begin
			sat_val = sum[CELL_W-1:0];
		end
		ram_we = v_s3 && upd_s3;
	end

	ocg_ram #(
		.WIDTH (CELL_W),
		.DEPTH (CELL_COUNT)
	) u_grid (
		.clk   (clk),
		.we    (ram_we),
		.waddr (raddr_q),
		.wdata (sat_val),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	logic                  m_tvalid_q;
	logic [M_TDATA_W-1:0]  m_tdata_q;
	logic signed [15:0]    res_cell_q;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			hit_inc_q   <= HIT_INC_RST;
			miss_inc_q  <= MISS_INC_RST;
			near_inc_q  <= NEAR_INC_RST;
			max_range_q <= MAX_RANGE_RST;
			issue_q     <= 1'b0;
			n_q         <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			reached_q   <= 1'b0;
			cnt_q       <= '0;
			valid_q     <= '0;
			fwd_q       <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_HIT:   hit_inc_q   <= cfg_data;
					CFG_MISS:  miss_inc_q  <= cfg_data;
					CFG_NEAR:  near_inc_q  <= cfg_data;
					CFG_RANGE: max_range_q <= cfg_data;
				endcase
			end

			if (issue_q) begin
				n_q <= n_q + 1'b1;
				if (n_q == LAST_N) begin
					issue_q <= 1'b0;
				end
			end
			v_s1 <= issue_q;
			v_s2 <= v_s1;
			v_s3 <= v_s2;

			if (upd_c) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (hit_c) begin
				reached_q <= 1'b1;
			end
			if (ram_we) begin
				valid_q[raddr_q] <= 1'b1;
			end
			fwd_q <= ram_we;

			if ((state_q == ST_DONE) && (!m_tvalid_q || m_tready)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (req) begin
						cnt_q     <= '0;
						reached_q <= 1'b0;
						n_q       <= '0;
						unique case (op)
							OP_RAY: begin
								if (ray_range < max_range_q) begin
									issue_q <= 1'b1;
									state_q <= ST_WALK;
								end else begin
									state_q <= ST_DONE;
								end
							end
							OP_READ:  state_q <= ST_READ;
							OP_CLEAR: begin
								valid_q <= '0;
								state_q <= ST_DONE;
							end
							OP_NOP:   state_q <= ST_DONE;
						endcase
					end
				end
				ST_WALK: begin
					if (v_s3 && last_s3) begin
						state_q <= ST_DONE;
					end
				end
				ST_READ: state_q <= ST_DONE;
				ST_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req) begin
			r0_q       <= round_q8(18'(GRID_CTR_Q8) + 18'(robot_x));
			c0_q       <= round_q8(18'(GRID_CTR_Q8) - 18'(robot_y));
			re_q       <= round_q8(18'(GRID_CTR_Q8) + 18'(robot_x) + 18'(ray_dx));
			ce_q       <= round_q8(18'(GRID_CTR_Q8) - 18'(robot_y) + 18'(ray_dy));
			dx_q       <= ray_dx;
			dy_q       <= ray_dy;
			acc_r_q    <= '0;
			acc_c_q    <= '0;
			res_cell_q <= '0;
		end else begin
			if (issue_q) begin
				acc_r_q <= acc_r_q + ACC_W'(dx_q);
				acc_c_q <= acc_c_q + ACC_W'(dy_q);
			end
			if (state_q == ST_READ) begin
				res_cell_q <= old_val;
			end
		end

		last_s1  <= issue_q && (n_q == LAST_N);
		neg_r_s1 <= neg_r;
		neg_c_s1 <= neg_c;
		x_r_s1   <= rnd_r[ACC_W-1:8];
		x_c_s1   <= rnd_c[ACC_W-1:8];

		last_s2  <= last_s1;
		neg_r_s2 <= neg_r_s1;
		neg_c_s2 <= neg_c_s1;
		q_r_s2   <= prod_r[SH +: Q_W];
		q_c_s2   <= prod_c[SH +: Q_W];

		last_s3  <= last_s2;
		upd_s3   <= upd_c;
		inc_s3   <= inc_c;
		raddr_q  <= ram_raddr;

		wr_addr_q <= raddr_q;
		wr_data_q <= sat_val;

		if ((state_q == ST_DONE) && (!m_tvalid_q || m_tready)) begin
			m_tdata_q <= {2'b00, reached_q, cnt_q, res_cell_q};
		end
	end

	a_write_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_WALK))
		else $error("grid write outside a ray walk");

	a_point_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> (state_q == ST_WALK))
		else $error("ray point in write stage outside a ray walk");

	a_request_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q != ST_IDLE))
		else $error("request taken without leaving idle");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> ($past(state_q) == ST_DONE))
		else $error("result issued without a finished request");

endmodule
